// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Included by files that carry concurrent checks; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at the same edge, held off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in non-overlapping form (|=>), held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/aid_pkg.sv
// Package for the ARM instruction decoder: class and operation codes, mode
// codes and the decoded word record. No dependencies.
package aid_pkg;

  localparam logic [2:0] CLS_UNKNOWN = 3'd0;
  localparam logic [2:0] CLS_DP      = 3'd1;
  localparam logic [2:0] CLS_MUL     = 3'd2;
  localparam logic [2:0] CLS_SWP     = 3'd3;
  localparam logic [2:0] CLS_LS      = 3'd4;
  localparam logic [2:0] CLS_BLK     = 3'd5;
  localparam logic [2:0] CLS_BR      = 3'd6;

  localparam logic [4:0] OP_MUL  = 5'd16;
  localparam logic [4:0] OP_MLA  = 5'd17;
  localparam logic [4:0] OP_SWP  = 5'd18;
  localparam logic [4:0] OP_SWPB = 5'd19;
  localparam logic [4:0] OP_LDR  = 5'd20;
  localparam logic [4:0] OP_LDRB = 5'd21;
  localparam logic [4:0] OP_STR  = 5'd22;
  localparam logic [4:0] OP_STRB = 5'd23;
  localparam logic [4:0] OP_LDM  = 5'd24;
  localparam logic [4:0] OP_STM  = 5'd25;
  localparam logic [4:0] OP_B    = 5'd26;
  localparam logic [4:0] OP_BL   = 5'd27;

  localparam logic [3:0] MODE_DP_IMM       = 4'd0;
  localparam logic [3:0] MODE_DP_SHIFT_IMM = 4'd1;
  localparam logic [3:0] MODE_DP_SHIFT_REG = 4'd2;
  localparam logic [3:0] MODE_LS_REG       = 4'd3;
  localparam logic [3:0] MODE_LS_SCALED    = 4'd6;
  localparam logic [3:0] MODE_BLK_DA       = 4'd2;

  localparam logic [31:0] MASK_MAJOR  = 32'h0C00_0000;
  localparam logic [31:0] MATCH_LS    = 32'h0400_0000;
  localparam logic [31:0] MASK_BR_BLK = 32'h0E00_0000;
  localparam logic [31:0] MATCH_BLK   = 32'h0800_0000;
  localparam logic [31:0] MATCH_BR    = 32'h0A00_0000;
  localparam logic [31:0] MASK_MUL    = 32'h0FC0_00F0;
  localparam logic [31:0] MATCH_MUL   = 32'h0000_0090;
  localparam logic [31:0] MASK_SWP    = 32'h0FB0_0FF0;
  localparam logic [31:0] MATCH_SWP   = 32'h0100_0090;

  typedef struct packed {
    logic [2:0]  instr_class;
    logic [4:0]  operation;
    logic [3:0]  condition;
    logic [3:0]  reg_n;
    logic [3:0]  reg_d;
    logic [3:0]  reg_m;
    logic [3:0]  reg_s;
    logic [2:0]  flag_bits;
    logic [3:0]  operand_mode;
    logic [1:0]  shift_kind;
    logic [31:0] immediate;
  } aid_result_t;

endpackage

// File: hw/rtl/aid_decode.sv
// Combinational ARM instruction field decode: one word in, one record out.
// Depends on aid_pkg.
module aid_decode
  import aid_pkg::*;
(
  input  logic [31:0] word,
  output aid_result_t result
);

  logic        p, u, b, wb, l;
  logic [1:0]  sub;
  logic [4:0]  rot;
  logic [63:0] rot_pair;

  assign p  = word[24];
  assign u  = word[23];
  assign b  = word[22];
  assign wb = word[21];
  assign l  = word[20];
  assign sub = p ? {1'b0, wb} : 2'd2;
  assign rot = {word[11:8], 1'b0};
  assign rot_pair = {24'd0, word[7:0], 24'd0, word[7:0]} >> rot;

  always_comb begin
    result = '0;
    result.condition = word[31:28];
    if ((word & MASK_MAJOR) == 32'd0) begin
      if ((word & MASK_MUL) == MATCH_MUL) begin
        result.instr_class = CLS_MUL;
        result.operation   = wb ? OP_MLA : OP_MUL;
        result.reg_n       = word[15:12];
        result.reg_d       = word[19:16];
        result.reg_m       = word[3:0];
        result.reg_s       = word[11:8];
        result.flag_bits   = {2'b00, l};
      end else if ((word & MASK_SWP) == MATCH_SWP) begin
        result.instr_class = CLS_SWP;
        result.operation   = b ? OP_SWPB : OP_SWP;
        result.reg_n       = word[19:16];
        result.reg_d       = word[15:12];
        result.reg_m       = word[3:0];
      end else begin
        result.instr_class = CLS_DP;
        result.operation   = {1'b0, word[24:21]};
        result.reg_n       = word[19:16];
        result.reg_d       = word[15:12];
        result.flag_bits   = {2'b00, l};
        if (word[25]) begin
          result.operand_mode = MODE_DP_IMM;
          result.immediate    = rot_pair[31:0];
        end else begin
          result.reg_m      = word[3:0];
          result.shift_kind = word[6:5];
          if (word[4]) begin
            result.operand_mode = MODE_DP_SHIFT_REG;
            result.reg_s        = word[11:8];
          end else begin
            result.operand_mode = MODE_DP_SHIFT_IMM;
            result.immediate    = {27'd0, word[11:7]};
          end
        end
      end
    end else if ((word & MASK_MAJOR) == MATCH_LS) begin
      result.instr_class = CLS_LS;
      result.operation   = l ? (b ? OP_LDRB : OP_LDR) : (b ? OP_STRB : OP_STR);
      result.reg_n       = word[19:16];
      result.reg_d       = word[15:12];
      result.flag_bits   = {(!p) || wb, u, 1'b0};
      if (word[25]) begin
        result.reg_m = word[3:0];
        if (word[11:4] != 8'd0) begin
          result.operand_mode = MODE_LS_SCALED + {2'b00, sub};
          result.shift_kind   = word[6:5];
          result.immediate    = {27'd0, word[11:7]};
        end else begin
          result.operand_mode = MODE_LS_REG + {2'b00, sub};
        end
      end else begin
        result.operand_mode = {2'b00, sub};
        result.immediate    = {20'd0, word[11:0]};
      end
    end else if ((word & MASK_BR_BLK) == MATCH_BLK) begin
      result.instr_class  = CLS_BLK;
      result.operation    = l ? OP_LDM : OP_STM;
      result.reg_n        = word[19:16];
      result.flag_bits    = {wb, u, 1'b0};
      result.operand_mode = (u ? 4'd0 : MODE_BLK_DA) + {3'd0, p};
      result.immediate    = {16'd0, word[15:0]};
    end else if ((word & MASK_BR_BLK) == MATCH_BR) begin
      result.instr_class = CLS_BR;
      result.operation   = p ? OP_BL : OP_B;
      result.immediate   = {{8{word[23]}}, word[23:0]};
    end
  end

endmodule

// File: hw/rtl/arm_instruction_decoder.sv
// ARM v4 instruction decoder, top level: input word register, decode logic,
// result register. Depends on aid_pkg, aid_decode and assert_macros.svh.
//
// One word enters per clock cycle while word_stall is low. An accepted word
// waits in the input register, then its record, with only the field decode
// between, is loaded into the result register that drives the result ports.
// Both registers advance together when the result is taken or empty; the
// input register also loads while it is empty. A result-side stall holds the
// result register and any full input register, and raises word_stall in the same cycle.
`include "assert_macros.svh"

module arm_instruction_decoder
  import aid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        word_valid,
  output logic        word_stall,
  input  logic [31:0] instruction_word,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  instr_class,
  output logic [4:0]  operation,
  output logic [3:0]  condition,
  output logic [3:0]  reg_n,
  output logic [3:0]  reg_d,
  output logic [3:0]  reg_m,
  output logic [3:0]  reg_s,
  output logic [2:0]  flag_bits,
  output logic [3:0]  operand_mode,
  output logic [1:0]  shift_kind,
  output logic [31:0] immediate
);

  logic        held_valid;
  logic [31:0] held_word;
  aid_result_t decoded;
  aid_result_t result;
  logic        out_free;
  logic        held_moving;
  logic        out_full;
  logic        out_unknown;
  logic        unknown_cleared;
  logic        out_branch;
  logic        branch_op_ok;

  aid_decode u_decode (
    .word   (held_word),
    .result (decoded)
  );

  assign out_free   = !result_valid || !result_stall;
  assign word_stall = held_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (out_free) begin
        result_valid <= held_valid;
        held_valid   <= word_valid;
      end else if (!held_valid) begin
        held_valid <= word_valid;
      end
    end
    if (word_valid && !word_stall) begin
      held_word <= instruction_word;
    end
    if (out_free && held_valid) begin
      result <= decoded;
    end
  end

  assign instr_class  = result.instr_class;
  assign operation    = result.operation;
  assign condition    = result.condition;
  assign reg_n        = result.reg_n;
  assign reg_d        = result.reg_d;
  assign reg_m        = result.reg_m;
  assign reg_s        = result.reg_s;
  assign flag_bits    = result.flag_bits;
  assign operand_mode = result.operand_mode;
  assign shift_kind   = result.shift_kind;
  assign immediate    = result.immediate;

  assign held_moving     = held_valid && out_free;
  assign out_full        = held_valid && result_valid;
  assign out_unknown     = result_valid && (instr_class == CLS_UNKNOWN);
  assign unknown_cleared = (operation == 5'd0) && (immediate == 32'd0) && (flag_bits == 3'd0);
  assign out_branch      = result_valid && (instr_class == CLS_BR);
  assign branch_op_ok    = (operation == OP_B) || (operation == OP_BL);

  `ASSERT_NEXT(a_held_moves_out, clk, rst, held_moving, result_valid, "held word lost")
  `ASSERT_IMPLY(a_stall_only_full, clk, rst, word_stall, out_full, "needless stall")
  `ASSERT_IMPLY(a_unknown_clear, clk, rst, out_unknown, unknown_cleared, "unknown not cleared")
  `ASSERT_IMPLY(a_branch_op, clk, rst, out_branch, branch_op_ok, "bad branch op")

endmodule
